FILE: design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/rnl_pkg.sv
// package for the rectangle nesting block: sizes, state and cell control types
package rnl_pkg;

  localparam int MAX_RECTS_DEF = 1024;
  localparam int SIDE_BITS_DEF = 16;
  localparam int IN_SIDE_W = 16;
  localparam int CHAIN_W = 11;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_COUNT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: design/rectangle_nesting_longest_chain.sv
// top level of the rectangle nesting longest chain block
//
//  channel  dir  fields (low bit up)
//  s_*      in   tdata: side_a[15:0], side_b[31:16]; tlast: set_last
//  m_*      out  tdata: chain_length[10:0], zeros above
//
// loading takes one rectangle per cycle into a sorting row of cells
// after the last rectangle the sorted set moves into the chain row (drain state),
// then the chain row is counted (count state); the result waits in an output register
// s_tready is low from the last rectangle until the result is taken
// reset clears valid bits and control; no clearing pass is needed
`include "assert_macros.svh"

module rectangle_nesting_longest_chain import rnl_pkg::*; #(
  parameter int MAX_RECTS = MAX_RECTS_DEF,
  parameter int SIDE_BITS = SIDE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // side_a, side_b
  input  logic                  s_tlast,   // set_last
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // chain_length
);

  localparam int SW = (SIDE_BITS < IN_SIDE_W) ? SIDE_BITS : IN_SIDE_W;
  localparam int CW = $clog2(MAX_RECTS + 1);

  state_t state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] len;
  cell_ctrl_t sort_ctrl, lis_ctrl;

  logic [SW-1:0] a, b, new_l, new_s;
  logic in_hs, out_hs, room;

  logic [SW-1:0] sl [MAX_RECTS+1];
  logic [SW-1:0] ss [MAX_RECTS+1];
  logic          sv [MAX_RECTS+1];
  logic          sg [MAX_RECTS+1];
  logic [SW-1:0] lt [MAX_RECTS+1];
  logic          lv [MAX_RECTS+1];
  logic          lg [MAX_RECTS+1];

  assign a = s_tdata[SW-1:0];
  assign b = s_tdata[IN_SIDE_W+SW-1:IN_SIDE_W];
  assign new_l = (a >= b) ? a : b;
  assign new_s = (a >= b) ? b : a;

  assign in_hs = s_tvalid && s_tready;
  assign out_hs = m_tvalid && m_tready;
  assign room = (count < CW'(MAX_RECTS));

  // end of each row reads as empty
  assign sl[MAX_RECTS] = '0;
  assign ss[MAX_RECTS] = '0;
  assign sv[MAX_RECTS] = 1'b0;
  assign sg[MAX_RECTS] = 1'b1;
  assign lt[MAX_RECTS] = '0;
  assign lv[MAX_RECTS] = 1'b0;
  assign lg[MAX_RECTS] = 1'b1;

  genvar i;
  generate
    for (i = 0; i < MAX_RECTS; i++) begin : g_cells
      logic          lgt_s, lgt_l, lval_s;
      logic [SW-1:0] ll, ls;
      if (i == 0) begin : g_first
        assign lgt_s = 1'b0;
        assign lgt_l = 1'b0;
        assign lval_s = 1'b0;
        assign ll = '0;
        assign ls = '0;
      end else begin : g_rest
        assign lgt_s = sg[i-1];
        assign lgt_l = lg[i-1];
        assign lval_s = sv[i-1];
        assign ll = sl[i-1];
        assign ls = ss[i-1];
      end
      rnl_sort_cell #(.SW(SW)) u_sort (
        .clk(clk), .rst(rst), .ctrl(sort_ctrl),
        .new_l(new_l), .new_s(new_s),
        .left_l(ll), .left_s(ls), .left_valid(lval_s), .left_gt(lgt_s),
        .right_l(sl[i+1]), .right_s(ss[i+1]), .right_valid(sv[i+1]),
        .cur_l(sl[i]), .cur_s(ss[i]), .valid(sv[i]), .gt(sg[i])
      );
      rnl_lis_cell #(.SW(SW)) u_lis (
        .clk(clk), .rst(rst), .ctrl(lis_ctrl),
        .x(ss[0]), .left_gt(lgt_l),
        .right_t(lt[i+1]), .right_valid(lv[i+1]),
        .cur_t(lt[i]), .valid(lv[i]), .gt(lg[i])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:  if (in_hs && s_tlast) state_next = ST_DRAIN;
      ST_DRAIN: if (count == CW'(1)) state_next = ST_COUNT;
      ST_COUNT: if (!lv[0]) state_next = ST_OUT;
      ST_OUT:   if (m_tready) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    sort_ctrl = '0;
    lis_ctrl = '0;
    case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        sort_ctrl.insert = in_hs && room;
      end
      ST_DRAIN: begin
        sort_ctrl.shift = 1'b1;
        lis_ctrl.insert = 1'b1;
      end
      ST_COUNT: lis_ctrl.shift = 1'b1;
      ST_OUT:   m_tvalid = 1'b1;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      len <= '0;
    end else begin
      state <= state_next;
      if (state == ST_LOAD && in_hs && room) begin
        count <= count + CW'(1);
      end else if (state == ST_DRAIN) begin
        count <= count - CW'(1);
      end
      if (state == ST_COUNT && lv[0]) begin
        len <= len + CW'(1);
      end else if (out_hs) begin
        len <= '0;
      end
    end
  end

  assign m_tdata = OUT_DATA_W'(CHAIN_W'(len));

  `ASSERT_CLK(a_result_nonzero, clk, rst, m_tvalid |-> (len != '0), "empty chain result")
  `ASSERT_CLK(a_drain_nonempty, clk, rst, (state == ST_DRAIN) |-> (count != '0), "drain with no rectangles")
  `ASSERT_CLK(a_back_to_load, clk, rst, out_hs |=> (state == ST_LOAD && len == '0), "no return to loading")
  `ASSERT_CLK(a_count_bound, clk, rst, count <= CW'(MAX_RECTS), "rectangle count overflow")

endmodule

FILE: design/rnl_sort_cell.sv
// one cell of the sorting row: holds a rectangle in lexicographic order
module rnl_sort_cell import rnl_pkg::*; #(
  parameter int SW = SIDE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_ctrl_t    ctrl,
  input  logic [SW-1:0] new_l,
  input  logic [SW-1:0] new_s,
  input  logic [SW-1:0] left_l,
  input  logic [SW-1:0] left_s,
  input  logic          left_valid,
  input  logic          left_gt,
  input  logic [SW-1:0] right_l,
  input  logic [SW-1:0] right_s,
  input  logic          right_valid,
  output logic [SW-1:0] cur_l,
  output logic [SW-1:0] cur_s,
  output logic          valid,
  output logic          gt
);

  // empty cells count as larger than any rectangle
  assign gt = !valid || (cur_l > new_l) || ((cur_l == new_l) && (cur_s > new_s));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end else if (ctrl.insert && gt) begin
      valid <= left_gt ? left_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      cur_l <= right_l;
      cur_s <= right_s;
    end else if (ctrl.insert && gt) begin
      cur_l <= left_gt ? left_l : new_l;
      cur_s <= left_gt ? left_s : new_s;
    end
  end

endmodule

FILE: design/rnl_lis_cell.sv
// one cell of the chain row: smallest tail short side of a chain of its length
module rnl_lis_cell import rnl_pkg::*; #(
  parameter int SW = SIDE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_ctrl_t    ctrl,
  input  logic [SW-1:0] x,
  input  logic          left_gt,
  input  logic [SW-1:0] right_t,
  input  logic          right_valid,
  output logic [SW-1:0] cur_t,
  output logic          valid,
  output logic          gt
);

  assign gt = !valid || (cur_t > x);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end else if (ctrl.insert && gt && !left_gt) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      cur_t <= right_t;
    end else if (ctrl.insert && gt && !left_gt) begin
      cur_t <= x;
    end
  end

endmodule

FILE: tb/rectangle_nesting_longest_chain_test.sv
// testbench for the rectangle nesting longest chain block: directed and random sets checked against a model
`timescale 1ns / 100ps

module rectangle_nesting_longest_chain_test;
  import rnl_pkg::*;

  class chain_scoreboard;
    logic [15:0] long_q[$];
    logic [15:0] short_q[$];
    int unsigned expected_len[$];
    int errors;
    int results;

    function void note_rect(logic [15:0] a, logic [15:0] b, bit last);
      int unsigned ch[$];
      int unsigned best;
      int unsigned m;
      logic [15:0] tl;
      logic [15:0] ts;
      int k;
      if (long_q.size() < MAX_RECTS_DEF) begin
        long_q.push_back(a >= b ? a : b);
        short_q.push_back(a >= b ? b : a);
      end
      if (!last) return;
      for (int i = 1; i < long_q.size(); i++) begin
        tl = long_q[i];
        ts = short_q[i];
        k = i;
        while (k > 0 && (long_q[k-1] > tl || (long_q[k-1] == tl && short_q[k-1] > ts))) begin
          long_q[k] = long_q[k-1];
          short_q[k] = short_q[k-1];
          k--;
        end
        long_q[k] = tl;
        short_q[k] = ts;
      end
      best = 0;
      for (int i = 0; i < long_q.size(); i++) begin
        m = 0;
        for (int j = 0; j < i; j++)
          if (short_q[j] <= short_q[i] && ch[j] > m) m = ch[j];
        ch.push_back(m + 1);
        if (m + 1 > best) best = m + 1;
      end
      expected_len.push_back(best & 11'h7ff);
      long_q.delete();
      short_q.delete();
    endfunction

    function void check_len(logic [OUT_DATA_W-1:0] d);
      int unsigned e;
      results++;
      if (expected_len.size() == 0) begin
        $error("unexpected result chain_length %0d", d[CHAIN_W-1:0]);
        errors++;
        return;
      end
      e = expected_len.pop_front();
      if (d[CHAIN_W-1:0] !== e[CHAIN_W-1:0]) begin
        $error("chain_length expected %0d actual %0d", e, d[CHAIN_W-1:0]);
        errors++;
      end
      if (d[OUT_DATA_W-1:CHAIN_W] !== '0) begin
        $error("tdata padding expected 0 actual %0h", d[OUT_DATA_W-1:CHAIN_W]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tlast = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_DATA_W-1:0] m_tdata;

  chain_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int rects_sent = 0;
  int sets_sent = 0;

  always #2 clk = ~clk;

  rectangle_nesting_longest_chain u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_len(m_tdata);
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_rect(logic [15:0] a, logic [15:0] b, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b, a};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_rect(a, b, last);
    rects_sent++;
    if (last) sets_sent++;
  endtask

  task automatic end_burst();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_side(int mode);
    case (mode)
      0: return 16'($urandom_range(15));
      1: return 16'($urandom_range(300));
      2: return 16'(16'hffff - $urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_set(int n);
    int mode;
    mode = $urandom_range(4);
    for (int i = 0; i < n; i++)
      send_rect(rand_side(mode), rand_side(mode), i == n - 1);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (sb.expected_len.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_rect(16'h0, 16'h0, 1);
    send_rect(16'hffff, 16'hffff, 1);
    send_rect(16'hffff, 16'h0, 0);
    send_rect(16'h0, 16'hffff, 1);
    send_rect(16'h5, 16'h3, 0);
    send_rect(16'h3, 16'h5, 0);
    send_rect(16'h4, 16'h4, 0);
    send_rect(16'h6, 16'h2, 0);
    send_rect(16'h7, 16'h7, 0);
    send_rect(16'haaaa, 16'h5555, 0);
    send_rect(16'h5555, 16'haaaa, 1);
    for (int i = 0; i < 8; i++) send_rect(16'(10 - i), 16'(10 - i), i == 7);
    end_burst();
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 59 : 11) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 59 : 11) : 0;
      if (ph == 0) hold_cycles = 400;
      for (int s = 0; s < 25; s++) send_random_set($urandom_range(1, 12));
      end_burst();
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 200; i++)
      send_rect(16'($urandom_range(40)), 16'($urandom_range(40)), i == 199);
    end_burst();
    wait_drained();
    repeat (50) @(posedge clk);
    $display("sent %0d rectangles in %0d sets, checked %0d chain lengths",
             rects_sent, sets_sent, sb.results);
    $display("phases: no idling, sender gaps, receiver stalls, both, long hold, large set");
    if (sb.errors == 0 && sb.expected_len.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
